@@ rtl/drt_pkg.sv @@
// Package for the dirty rectangle tracker: item types, codes and default constants.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package drt_pkg;

	localparam int RING_SLOTS_DEF = 64;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int EDGE_W     = 13;
	localparam int LINE_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [EDGE_W-1:0] EDGE_MAX = 13'h1FFF;

	typedef enum logic [1:0] {
		CMD_RECT  = 2'd0,
		CMD_PAGE  = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_SENT     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NONE     = 2'd3
	} status_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_LINE_BYTES    = 2'd2,
		REG_PAGE_COUNT    = 2'd3
	} cfg_reg_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV1,
		S_DIV2,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] rect_x;
		logic [11:0] rect_y;
		logic [11:0] rect_w;
		logic [11:0] rect_h;
		logic [11:0] page_number;
		logic [31:0] ring_consumed;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [EDGE_W-1:0] upd_x;
		logic [EDGE_W-1:0] upd_y;
		logic [EDGE_W-1:0] upd_w;
		logic [EDGE_W-1:0] upd_h;
		logic [31:0]       produced;
	} upd_item_t;

endpackage

@@ rtl/drt_cmd_if.sv @@
// Command channel of the dirty rectangle tracker: valid, ready and one command item.
// Depends on drt_pkg for the item type.
`timescale 1ns / 1ps

interface drt_cmd_if;
	logic              valid;
	logic              ready;
	drt_pkg::cmd_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

@@ rtl/drt_upd_if.sv @@
// Result channel of the dirty rectangle tracker: valid, ready and one update item.
// Depends on drt_pkg for the item type.
`timescale 1ns / 1ps

interface drt_upd_if;
	logic              valid;
	logic              ready;
	drt_pkg::upd_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

@@ rtl/dirty_rect_tracker.sv @@
// Top level of the dirty rectangle tracker: sequencer, damage box, producer index and result register.
// Depends on drt_pkg, drt_cmd_if, drt_upd_if and drt_div.
//
//   channel    direction  handshake              payload
//   cmd        in         cmd.valid / cmd.ready  drt_pkg::cmd_item_t
//   upd        out        upd.valid / upd.ready  drt_pkg::upd_item_t
//   cfg        in         cfg_we                 cfg_idx, cfg_wdata
//
// Rectangle, flush and out-of-range page commands pass from EXEC to APPLY, which loads the result.
// A page command passes from EXEC through DIV1 and DIV2 to APPLY, DW = clog2(4096*PAGE_BYTES), 24 at the default:
// the divider yields one quotient bit per cycle and is used for the start row, then the end row.
// A new command is taken once the previous result sits in the output register.
// A stalled result holds the sequencer in its final state. Reset is asynchronous, with no clearing pass.
`timescale 1ns / 1ps

module dirty_rect_tracker #(
	parameter int RING_SLOTS = drt_pkg::RING_SLOTS_DEF,
	parameter int PAGE_BYTES = drt_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	drt_cmd_if.sink                         cmd,
	drt_upd_if.source                       upd,
	input  logic                            cfg_we,
	input  logic [drt_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [drt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int DW = $clog2(4096 * PAGE_BYTES);
	localparam int EW = drt_pkg::EDGE_W;
	localparam int LW = drt_pkg::LINE_W;

	drt_pkg::state_t    state_q, state_d;
	drt_pkg::cmd_item_t item_q;
	drt_pkg::upd_item_t out_q, res;
	logic               out_valid_q;
	logic               out_load;
	logic               in_ready;

	logic [11:0]   width_q, height_q;
	logic [LW-1:0] line_q;
	logic [12:0]   pages_q;

	logic [EW-1:0] left_q, top_q, right_q, bottom_q;
	logic          dirty_q;
	logic [31:0]   prod_q;
	logic [EW-1:0] r1_q;

	logic          div_start, div_done;
	logic [DW-1:0] div_dividend, div_quo;
	logic [LW-1:0] divisor;
	logic [DW-1:0] start_bytes, end_bytes;
	logic          page_bad;
	logic [EW-1:0] r1_sat, r2_clamp;

	logic [EW-1:0] x1, y1, x2, y2;
	logic          grow, sent;
	logic [31:0]   used;

	assign divisor     = (line_q == '0) ? LW'(1) : line_q;
	assign start_bytes = DW'(item_q.page_number) * DW'(PAGE_BYTES);
	assign end_bytes   = start_bytes + DW'(PAGE_BYTES - 1);
	assign page_bad    = {1'b0, item_q.page_number} >= pages_q;
	assign r1_sat      = (div_quo > DW'(drt_pkg::EDGE_MAX)) ? drt_pkg::EDGE_MAX : div_quo[EW-1:0];
	assign r2_clamp    = (div_quo > DW'(height_q)) ? {1'b0, height_q} : div_quo[EW-1:0];

	drt_div #(
		.DW (DW),
		.LW (LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = start_bytes;
		out_load     = 1'b0;
		unique case (state_q)
			drt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (cmd.valid) begin
					state_d = drt_pkg::S_EXEC;
				end
			end
			drt_pkg::S_EXEC: begin
				if (item_q.command == drt_pkg::CMD_PAGE && !page_bad) begin
					div_start = 1'b1;
					state_d   = drt_pkg::S_DIV1;
				end else begin
					state_d = drt_pkg::S_APPLY;
				end
			end
			drt_pkg::S_DIV1: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = end_bytes;
					state_d      = drt_pkg::S_DIV2;
				end
			end
			drt_pkg::S_DIV2: begin
				if (div_done) begin
					state_d = drt_pkg::S_APPLY;
				end
			end
			drt_pkg::S_APPLY: begin
				if (!out_valid_q || upd.ready) begin
					out_load = 1'b1;
					state_d  = drt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = drt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		x1   = '0;
		y1   = '0;
		x2   = '0;
		y2   = '0;
		grow = 1'b0;
		sent = 1'b0;
		used = prod_q - item_q.ring_consumed;
		res  = '0;
		res.status = drt_pkg::ST_NONE;
		unique case (item_q.command)
			drt_pkg::CMD_RECT: begin
				x1   = {1'b0, item_q.rect_x};
				y1   = {1'b0, item_q.rect_y};
				x2   = {1'b0, item_q.rect_x} + {1'b0, item_q.rect_w};
				y2   = {1'b0, item_q.rect_y} + {1'b0, item_q.rect_h};
				grow = 1'b1;
				res.status = drt_pkg::ST_ACCEPTED;
			end
			drt_pkg::CMD_PAGE: begin
				if (page_bad) begin
					res.status = drt_pkg::ST_RANGE;
				end else begin
					y1   = r1_q;
					x2   = {1'b0, width_q};
					y2   = r2_clamp;
					grow = 1'b1;
					res.status = drt_pkg::ST_ACCEPTED;
				end
			end
			drt_pkg::CMD_FLUSH: begin
				if (used < 32'(RING_SLOTS) && dirty_q) begin
					sent       = 1'b1;
					res.status = drt_pkg::ST_SENT;
					res.upd_x  = left_q;
					res.upd_y  = top_q;
					res.upd_w  = (right_q >= left_q) ? right_q - left_q : '0;
					res.upd_h  = (bottom_q >= top_q) ? bottom_q - top_q : '0;
				end
			end
			default: begin
				res.status = drt_pkg::ST_NONE;
			end
		endcase
		res.produced = sent ? prod_q + 32'd1 : prod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 12'd800;
			height_q    <= 12'd600;
			line_q      <= LW'(3200);
			pages_q     <= 13'd469;
			left_q      <= drt_pkg::EDGE_MAX;
			top_q       <= drt_pkg::EDGE_MAX;
			right_q     <= '0;
			bottom_q    <= '0;
			dirty_q     <= 1'b0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (drt_pkg::cfg_reg_e'(cfg_idx))
					drt_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata[11:0];
					drt_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata[11:0];
					drt_pkg::REG_LINE_BYTES:    line_q   <= cfg_wdata[LW-1:0];
					drt_pkg::REG_PAGE_COUNT:    pages_q  <= cfg_wdata[12:0];
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				prod_q      <= res.produced;
				if (sent) begin
					left_q   <= drt_pkg::EDGE_MAX;
					top_q    <= drt_pkg::EDGE_MAX;
					right_q  <= '0;
					bottom_q <= '0;
					dirty_q  <= 1'b0;
				end else if (grow) begin
					left_q   <= (x1 < left_q) ? x1 : left_q;
					top_q    <= (y1 < top_q) ? y1 : top_q;
					right_q  <= (x2 > right_q) ? x2 : right_q;
					bottom_q <= (y2 > bottom_q) ? y2 : bottom_q;
					dirty_q  <= 1'b1;
				end
			end else if (upd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && cmd.valid) begin
			item_q <= cmd.item;
		end
		if (state_q == drt_pkg::S_DIV1 && div_done) begin
			r1_q <= r1_sat;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign cmd.ready = in_ready;
	assign upd.valid = out_valid_q;
	assign upd.item  = out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == drt_pkg::S_DIV1 || state_q == drt_pkg::S_DIV2))
		else $error("divider finished outside a division state");

	a_prod_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prod_q) |-> prod_q == $past(prod_q) + 32'd1)
		else $error("producer index moved by other than one");

	a_clean_box: assert property (@(posedge clk) disable iff (!arst_n)
		!dirty_q |-> (left_q == drt_pkg::EDGE_MAX && top_q == drt_pkg::EDGE_MAX
			&& right_q == '0 && bottom_q == '0))
		else $error("clean box does not hold its empty value");

	a_dirty_cols: assert property (@(posedge clk) disable iff (!arst_n)
		dirty_q |-> left_q <= right_q)
		else $error("dirty box has its left edge past its right edge");

endmodule

@@ rtl/drt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, shared by both page row divisions.
// Depends on no other file of the project.
`timescale 1ns / 1ps

module drt_div #(
	parameter int DW = 24,
	parameter int LW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [LW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [LW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [LW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [LW:0]   shifted;
	logic [LW+1:0] diff;
	logic          bit_ok;

	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		bit_ok  = ~diff[LW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= bit_ok ? diff[LW-1:0] : shifted[LW-1:0];
			quo_q <= {quo_q[DW-2:0], bit_ok};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> rem_q < dvs_q)
		else $error("divider remainder reached the divisor");

endmodule
